[src/srbi_pkg.sv]
// ----------------------------------------------------------------------------
// srbi_pkg
// shared widths, constants and types of the swept ray box intersect block
// ----------------------------------------------------------------------------
package srbi_pkg;

  localparam int DIFF_W  = 35;
  localparam int FRAC_W  = 16;
  localparam int NUM_W   = DIFF_W + FRAC_W;
  localparam int Q_W     = 32;
  localparam int DIV_LAT = Q_W + 2;

  localparam logic signed [31:0] T_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] T_MIN = 32'sh80000000;
  localparam logic signed [31:0] T_ONE = 32'sh00010000;

  localparam logic signed [1:0] NRM_POS  = 2'sb01;
  localparam logic signed [1:0] NRM_NEG  = 2'sb11;
  localparam logic signed [1:0] NRM_ZERO = 2'sb00;

  typedef struct packed {
    logic               bad;
    logic signed [31:0] t;
  } div_res_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [32:0] ox;
    logic signed [32:0] oy;
  } side_t;

endpackage

[src/srbi_div.sv]
// ----------------------------------------------------------------------------
// srbi_div
// pipelined restoring divider: saturated q16.16 slab time, one bit per stage
// ----------------------------------------------------------------------------
module srbi_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [srbi_pkg::DIFF_W-1:0] diff,
  input  logic signed [31:0]                 dir,
  output srbi_pkg::div_res_t                 res
);
  import srbi_pkg::*;

  logic [NUM_W-1:0] rem_s [0:Q_W];
  logic [31:0]      den_s [0:Q_W];
  logic             neg_s [0:Q_W];
  logic             dz_s  [0:Q_W];
  logic             nz_s  [0:Q_W];
  logic [Q_W-1:0]   q_s   [1:Q_W];
  logic             ovf_s [1:Q_W];

  logic [DIFF_W-1:0] diff_mag;
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= {diff_mag, {FRAC_W{1'b0}}};
      den_s[0] <= dir[31] ? 32'(-dir) : 32'(dir);
      neg_s[0] <= diff[DIFF_W-1] ^ dir[31];
      dz_s[0]  <= (dir == 32'sd0);
      nz_s[0]  <= (diff != '0);
    end
  end

  for (genvar j = 1; j <= Q_W; j++) begin : g_step
    localparam int B = Q_W - j;
    logic [63:0] trial;
    logic [63:0] rem_ext;
    logic        take;
    logic        ovf_n;
    logic [Q_W-1:0] q_n;

    assign trial   = {32'b0, den_s[j-1]} << B;
    assign rem_ext = {{(64-NUM_W){1'b0}}, rem_s[j-1]};
    assign take    = (rem_ext >= trial);

    if (j == 1) begin : g_first
      assign ovf_n = (rem_ext >= {den_s[0], 32'b0});
      assign q_n   = {{(Q_W-1){1'b0}}, take};
    end else begin : g_rest
      assign ovf_n = ovf_s[j-1];
      assign q_n   = {q_s[j-1][Q_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[j] <= take ? NUM_W'(rem_ext - trial) : rem_s[j-1];
        den_s[j] <= den_s[j-1];
        neg_s[j] <= neg_s[j-1];
        dz_s[j]  <= dz_s[j-1];
        nz_s[j]  <= nz_s[j-1];
        q_s[j]   <= q_n;
        ovf_s[j] <= ovf_n;
      end
    end
  end

  logic [Q_W-1:0] q_f;
  assign q_f = q_s[Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (dz_s[Q_W]) begin
        res.bad <= !nz_s[Q_W];
        res.t   <= neg_s[Q_W] ? T_MIN : T_MAX;
      end else begin
        res.bad <= 1'b0;
        if (!neg_s[Q_W]) begin
          res.t <= (ovf_s[Q_W] || q_f[Q_W-1]) ? T_MAX : $signed(q_f);
        end else begin
          res.t <= (ovf_s[Q_W] || (q_f[Q_W-1] && (q_f[Q_W-2:0] != '0))) ?
                   T_MIN : $signed(32'(-q_f));
        end
      end
    end
  end

endmodule

[src/swept_ray_box_intersect.sv]
// ----------------------------------------------------------------------------
// swept_ray_box_intersect
// 2d slab test of a ray or a swept box against a box, q16.16
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with one test per beat; mode 0 casts a
// ray from start along dir, mode 1 sweeps a box of mover size from start.
// output channel: out_valid / out_stall with hit, entry and exit time, hit
// point and face normal; all fields read zero on a miss.
// pipeline: one edge stage, the four bit-per-stage dividers, then the
// interval compare, multiply and hit point stages.
// throughput: one beat per cycle while out_stall does not hold a result;
// the divider pipeline takes a new test every cycle unless stalled.
// out_stall freezes the whole pipeline while a result waits, and in_stall
// is raised in that cycle; nothing is dropped or repeated.
// reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module swept_ray_box_intersect (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic signed [31:0] box_left,
  input  logic signed [31:0] box_top,
  input  logic [30:0]        box_width,
  input  logic [30:0]        box_height,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic [30:0]        mover_width,
  input  logic [30:0]        mover_height,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic signed [31:0] entry_time,
  output logic signed [31:0] exit_time,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y,
  output logic signed [1:0]  normal_x,
  output logic signed [1:0]  normal_y
);
  import srbi_pkg::*;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // edge stage
  logic signed [DIFF_W-1:0] mwh_x, mwh_y, el, er, et, eb, org_x, org_y;
  assign mwh_x = mode ? $signed({5'b0, mover_width[30:1]})  : '0;
  assign mwh_y = mode ? $signed({5'b0, mover_height[30:1]}) : '0;
  assign el    = $signed({{3{box_left[31]}}, box_left}) - mwh_x;
  assign et    = $signed({{3{box_top[31]}}, box_top}) - mwh_y;
  assign er    = el + $signed({4'b0, box_width})
                 + (mode ? $signed({4'b0, mover_width}) : '0);
  assign eb    = et + $signed({4'b0, box_height})
                 + (mode ? $signed({4'b0, mover_height}) : '0);
  assign org_x = $signed({{3{start_x[31]}}, start_x}) + mwh_x;
  assign org_y = $signed({{3{start_y[31]}}, start_y}) + mwh_y;

  logic                     v0;
  logic signed [DIFF_W-1:0] d_nx, d_fx, d_ny, d_fy;
  side_t                    sb0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_nx    <= el - org_x;
      d_fx    <= er - org_x;
      d_ny    <= et - org_y;
      d_fy    <= eb - org_y;
      sb0.mode <= mode;
      sb0.dx   <= dir_x;
      sb0.dy   <= dir_y;
      sb0.ox   <= org_x[32:0];
      sb0.oy   <= org_y[32:0];
    end
  end

  // divider lanes
  div_res_t r_nx, r_fx, r_ny, r_fy;
  srbi_div u_div_nx (.clk(clk), .en(adv), .diff(d_nx), .dir(sb0.dx), .res(r_nx));
  srbi_div u_div_fx (.clk(clk), .en(adv), .diff(d_fx), .dir(sb0.dx), .res(r_fx));
  srbi_div u_div_ny (.clk(clk), .en(adv), .diff(d_ny), .dir(sb0.dy), .res(r_ny));
  srbi_div u_div_fy (.clk(clk), .en(adv), .diff(d_fy), .dir(sb0.dy), .res(r_fy));

  logic  vd [0:DIV_LAT-1];
  side_t sd [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) vd[i] <= 1'b0;
    end else if (adv) begin
      vd[0] <= v0;
      for (int i = 1; i < DIV_LAT; i++) vd[i] <= vd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= sb0;
      for (int i = 1; i < DIV_LAT; i++) sd[i] <= sd[i-1];
    end
  end

  // interval stage
  logic signed [31:0] nxs, fxs, nys, fys, near_c, far_c;
  logic               miss_c;
  side_t              sq;
  assign sq     = sd[DIV_LAT-1];
  assign nxs    = (r_nx.t > r_fx.t) ? r_fx.t : r_nx.t;
  assign fxs    = (r_nx.t > r_fx.t) ? r_nx.t : r_fx.t;
  assign nys    = (r_ny.t > r_fy.t) ? r_fy.t : r_ny.t;
  assign fys    = (r_ny.t > r_fy.t) ? r_ny.t : r_fy.t;
  assign near_c = (nxs > nys) ? nxs : nys;
  assign far_c  = (fxs < fys) ? fxs : fys;
  assign miss_c = r_nx.bad || r_fx.bad || r_ny.bad || r_fy.bad
                  || (nxs >= fys) || (nys >= fxs) || (far_c < 32'sd0)
                  || (sq.mode ? (near_c >= T_ONE) : (near_c > T_ONE));

  logic               v1, miss1, xsel1;
  logic signed [31:0] near1, far1;
  side_t              s1;

  always_ff @(posedge clk) begin
    if (adv) begin
      miss1 <= miss_c;
      xsel1 <= (nxs > nys);
      near1 <= near_c;
      far1  <= far_c;
      s1    <= sq;
    end
  end

  // multiply stage
  logic               v2, miss2, xsel2;
  logic signed [31:0] near2, far2;
  logic signed [63:0] px, py;
  side_t              s2;

  always_ff @(posedge clk) begin
    if (adv) begin
      miss2 <= miss1;
      xsel2 <= xsel1;
      near2 <= near1;
      far2  <= far1;
      s2    <= s1;
      px    <= s1.dx * near1;
      py    <= s1.dy * near1;
    end
  end

  // hit point stage
  logic signed [48:0] sx, sy;
  logic signed [31:0] hx_c, hy_c;
  assign sx   = $signed({{16{s2.ox[32]}}, s2.ox}) + $signed({px[63], px[63:16]});
  assign sy   = $signed({{16{s2.oy[32]}}, s2.oy}) + $signed({py[63], py[63:16]});
  assign hx_c = (sx > 49'sh0_7fff_ffff) ? T_MAX :
                (sx < -49'sh0_8000_0000) ? T_MIN : sx[31:0];
  assign hy_c = (sy > 49'sh0_7fff_ffff) ? T_MAX :
                (sy < -49'sh0_8000_0000) ? T_MIN : sy[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= vd[DIV_LAT-1];
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (miss2) begin
        hit        <= 1'b0;
        entry_time <= '0;
        exit_time  <= '0;
        hit_x      <= '0;
        hit_y      <= '0;
        normal_x   <= NRM_ZERO;
        normal_y   <= NRM_ZERO;
      end else begin
        hit        <= 1'b1;
        entry_time <= near2;
        exit_time  <= far2;
        hit_x      <= hx_c;
        hit_y      <= hy_c;
        normal_x   <= xsel2 ? (s2.dx[31] ? NRM_POS : NRM_NEG) : NRM_ZERO;
        normal_y   <= xsel2 ? NRM_ZERO : (s2.dy[31] ? NRM_POS : NRM_NEG);
      end
    end
  end

  a_stall_rule: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output back-pressure");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (entry_time == 32'sd0 && exit_time == 32'sd0
                             && normal_x == NRM_ZERO && normal_y == NRM_ZERO))
    else $error("miss beat carries nonzero fields");

  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (entry_time <= exit_time && exit_time >= 32'sd0
                            && (normal_x == NRM_ZERO || normal_y == NRM_ZERO)))
    else $error("hit beat with inconsistent times or normal");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(entry_time) && $stable(hit_x)))
    else $error("stalled output beat changed");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the swept ray box intersect block
// ----------------------------------------------------------------------------
// A short table of directed tests is followed by random tests, most of them
// rays or swept boxes aimed near a box and the rest fully random bits. Each
// accepted input beat is queued with its table row's result or a slab-test
// predictor's. Each output beat is checked against the oldest queued result.
// Both sides idle at random in several phases. In one phase the receiver holds
// off for a long stretch, so the pipeline fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import srbi_pkg::*;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] box_left;
    logic signed [31:0] box_top;
    logic [30:0]        box_width;
    logic [30:0]        box_height;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic [30:0]        mover_width;
    logic [30:0]        mover_height;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
  } shot_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] entry_t;
    logic signed [31:0] leave_t;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [1:0]  normal_x;
    logic signed [1:0]  normal_y;
  } hit_res_t;

  typedef struct {
    shot_t    shot;
    bit       typed;
    hit_res_t res;
  } row_t;

  localparam int NUM_PHASES = 5;
  localparam int PH_PRESS   = 4;
  localparam int PER_PHASE  = 380;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_LEN  = 60;
  localparam int DOG_LIMIT  = 20000;
  localparam int TX_IDLE [NUM_PHASES] = '{0, 58, 0, 28, 0};
  localparam int RX_IDLE [NUM_PHASES] = '{0, 0, 58, 28, 0};

  logic               clk, rst;
  logic               in_valid, in_stall, out_valid, out_stall;
  logic               mode;
  logic signed [31:0] box_left, box_top, start_x, start_y, dir_x, dir_y;
  logic [30:0]        box_width, box_height, mover_width, mover_height;
  logic               hit;
  logic signed [31:0] entry_time, exit_time, hit_x, hit_y;
  logic signed [1:0]  normal_x, normal_y;

  hit_res_t hit_queue[$];
  int       phase = 0;
  bit       held = 0;
  int       mismatches = 0;
  int       dog = 0;

  swept_ray_box_intersect dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // slab crossing time, 0 on the 0/0 case
  function automatic bit slab_time(longint diff, longint d, output longint t);
    t = 0;
    if (d == 0) begin
      if (diff == 0) return 0;
      t = diff > 0 ? longint'(T_MAX) : longint'(T_MIN);
      return 1;
    end
    t = sat_q((diff * 65536) / d);
    return 1;
  endfunction

  function automatic hit_res_t predict_hit(shot_t s);
    longint bl, bt, bw, bh, ox, oy, dx, dy, hw, hh;
    longint nx, fx, ny, fy, tmp, near_t, far_t;
    bit ok;
    hit_res_t r;
    r = '0;
    bl = s.box_left; bt = s.box_top;
    bw = s.box_width; bh = s.box_height;
    ox = s.start_x; oy = s.start_y;
    dx = s.dir_x; dy = s.dir_y;
    if (s.mode) begin
      hw = s.mover_width >> 1;
      hh = s.mover_height >> 1;
      bl -= hw; bt -= hh;
      bw += s.mover_width; bh += s.mover_height;
      ox += hw; oy += hh;
    end
    ok = slab_time(bl - ox, dx, nx);
    ok = slab_time(bl + bw - ox, dx, fx) && ok;
    ok = slab_time(bt - oy, dy, ny) && ok;
    ok = slab_time(bt + bh - oy, dy, fy) && ok;
    if (!ok) return r;
    if (nx > fx) begin tmp = nx; nx = fx; fx = tmp; end
    if (ny > fy) begin tmp = ny; ny = fy; fy = tmp; end
    if (nx >= fy || ny >= fx) return r;
    near_t = nx > ny ? nx : ny;
    far_t = fx < fy ? fx : fy;
    if (far_t < 0) return r;
    if (s.mode ? (near_t >= 65536) : (near_t > 65536)) return r;
    r.hit = 1;
    r.entry_t = near_t[31:0];
    r.leave_t = far_t[31:0];
    r.hit_x = 32'(sat_q(ox + ((dx * near_t) >>> 16)));
    r.hit_y = 32'(sat_q(oy + ((dy * near_t) >>> 16)));
    if (nx > ny) begin
      r.normal_x = dx < 0 ? NRM_POS : NRM_NEG;
      r.normal_y = NRM_ZERO;
    end else begin
      r.normal_x = NRM_ZERO;
      r.normal_y = dy < 0 ? NRM_POS : NRM_NEG;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] near_coord();
    return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  function automatic shot_t random_shot();
    logic [351:0] raw;
    shot_t s;
    if ($urandom_range(0, 99) < 15) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
      s = raw[$bits(shot_t)-1:0];
    end else begin
      s.mode = 1'($urandom_range(0, 1));
      s.box_left = near_coord();
      s.box_top = near_coord();
      s.box_width = 31'($urandom_range(0, 32'h0030_0000));
      s.box_height = 31'($urandom_range(0, 32'h0030_0000));
      s.start_x = near_coord();
      s.start_y = near_coord();
      s.mover_width = 31'($urandom_range(0, 32'h0010_0000));
      s.mover_height = 31'($urandom_range(0, 32'h0010_0000));
      s.dir_x = $urandom_range(0, 7) == 0 ? 32'sd0 : near_coord() <<< 1;
      s.dir_y = $urandom_range(0, 7) == 0 ? 32'sd0 : near_coord() <<< 1;
      if ($urandom_range(0, 9) == 0) s.dir_x = (s.box_left - s.start_x);
    end
    return s;
  endfunction

  task automatic send_beat(shot_t s, bit typed, hit_res_t e);
    if ($urandom_range(0, 99) < TX_IDLE[phase]) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    {mode, box_left, box_top, box_width, box_height, start_x, start_y,
     mover_width, mover_height, dir_x, dir_y} <= s;
    do @(posedge clk); while (in_stall);
    hit_queue.push_back(typed ? e : predict_hit(s));
  endtask

  // receiver side, with one long hold-off in the pressure phase
  initial begin
    out_stall <= 0;
    forever begin
      @(posedge clk);
      if (phase == PH_PRESS && !held) begin
        out_stall <= 1;
        repeat (HOLD_LEN) @(posedge clk);
        held = 1;
        out_stall <= 0;
      end else begin
        out_stall <= $urandom_range(0, 99) < RX_IDLE[phase];
      end
    end
  end

  always @(posedge clk) begin
    hit_res_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {hit, entry_time, exit_time, hit_x, hit_y, normal_x, normal_y};
      if (hit_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        want = hit_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) dog <= 0;
    else dog <= dog + 1;
    if (dog == DOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    shot_t s;
    rst <= 1;
    in_valid <= 0;
    {mode, box_left, box_top, box_width, box_height, start_x, start_y,
     mover_width, mover_height, dir_x, dir_y} <= '0;

    // all zero: 0/0 on both axes, a miss
    rows.push_back('{'0, 1, '0});
    // ray along +x entering the left face at half time
    s = '0;
    s.box_left = 32'sh0001_0000; s.box_top = -32'sh0001_0000;
    s.box_width = 31'h0001_0000; s.box_height = 31'h0002_0000;
    s.dir_x = 32'sh0002_0000;
    rows.push_back('{s, 1, '{1, 32'sh8000, 32'sh1_0000, 32'sh1_0000, 0, NRM_NEG, NRM_ZERO}});
    // same ray swept with a zero mover
    s.mode = 1;
    rows.push_back('{s, 0, '0});
    // entry exactly at one: hit for a ray, miss for a swept box
    s.box_left = 32'sh0002_0000; s.mode = 0;
    rows.push_back('{s, 0, '0});
    s.mode = 1;
    rows.push_back('{s, 1, '0});
    // swept box of nonzero size, odd sizes
    s.mover_width = 31'h0000_8001; s.mover_height = 31'h0001_0003;
    s.box_left = 32'sh0001_0000;
    rows.push_back('{s, 0, '0});
    // box behind the ray
    s.mode = 0; s.dir_x = -32'sh0002_0000;
    rows.push_back('{s, 0, '0});
    // going down-left into the box from the upper right
    s.start_x = 32'sh0004_0000; s.start_y = 32'sh0003_0000;
    s.dir_x = -32'sh0004_0000; s.dir_y = -32'sh0004_0000;
    rows.push_back('{s, 0, '0});
    // disjoint intervals
    s.dir_y = 32'sh0004_0000;
    rows.push_back('{s, 0, '0});
    // field extremes
    rows.push_back('{'1, 0, '0});
    s = '1; s.box_left = T_MIN; s.box_top = T_MIN; s.start_x = T_MIN;
    s.start_y = T_MIN; s.dir_x = T_MIN; s.dir_y = T_MIN;
    rows.push_back('{s, 0, '0});
    s.box_left = T_MAX; s.start_x = T_MIN; s.dir_x = 32'sd1; s.dir_y = T_MAX;
    rows.push_back('{s, 0, '0});
    s.mode = 0; s.dir_x = 32'sd0; s.dir_y = -32'sd1;
    rows.push_back('{s, 0, '0});
    s = '0; s.box_width = '1; s.box_height = '1; s.box_left = T_MIN;
    s.box_top = T_MIN; s.dir_x = T_MAX; s.dir_y = T_MIN;
    rows.push_back('{s, 0, '0});
    s.mode = 1; s.mover_width = '1; s.mover_height = '1;
    rows.push_back('{s, 0, '0});
    // zero direction with the origin inside the slab
    s = '0; s.box_left = -32'sh1_0000; s.box_top = -32'sh1_0000;
    s.box_width = 31'h2_0000; s.box_height = 31'h2_0000; s.dir_y = 32'sh1_0000;
    rows.push_back('{s, 0, '0});
    // zero direction on the slab edge: 0/0 miss
    s.box_left = 32'sh0;
    rows.push_back('{s, 1, '0});

    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[i]) send_beat(rows[i].shot, rows[i].typed, rows[i].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      phase = p;
      for (int i = 0; i < PER_PHASE; i++) send_beat(random_shot(), 0, '0);
    end
    in_valid <= 0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
